// ===== design/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
// Used by mexp_mulmod and mod_exp; depends on nothing else.
package mexp_pkg;

	localparam int DATA_W       = 31;
	localparam int CNT_W        = $clog2(DATA_W);
	localparam int EXP_BITS_DEF = 63;
	localparam int EXP_W        = 63;

	typedef logic [DATA_W-1:0] word_t;

	localparam word_t MODULUS_RESET = word_t'(1000000007);
	localparam word_t WORD_ONE      = word_t'(1);
	localparam word_t WORD_TWO      = word_t'(2);

	// Request to the bit-serial modular multiplier: a is the multiplicand
	// (below the modulus), b the multiplier, scanned one bit a cycle.
	typedef struct packed {
		logic  start;
		word_t a;
		word_t b;
	} mm_req_t;

	typedef struct packed {
		logic  done;
		word_t res;
	} mm_rsp_t;

endpackage

// ===== design/mod_exp.sv =====
// Modular exponentiation top level: sequencer, exponent shift register, config.
// Depends on mexp_pkg and mexp_mulmod.
//
// Computes base^exponent mod modulus by right-to-left square-and-multiply.
// Pulse start while busy is low; the result appears on power_result for
// exactly one cycle with done high and cannot be held off, so capture it then.
// Every modular product goes through one shared bit-serial multiplier at one
// bit per cycle. An item takes one product to reduce the base, one squaring
// for each exponent bit below the highest set bit and one multiply for each
// set bit. A zero exponent gives 1 after the reduction; a modulus below 2
// gives 0 without using the multiplier. cfg_ready is low while busy is high
// or start is raised, so a modulus transfer never lands on an item in flight.
module mod_exp #(
	parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  mexp_pkg::word_t             base,
	input  logic [mexp_pkg::EXP_W-1:0]  exponent,
	output logic                        done,
	output mexp_pkg::word_t             power_result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  mexp_pkg::word_t             cfg_data
);
	import mexp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_STEP,
		ST_MUL,
		ST_SQR
	} state_t;

	state_t              state_q;
	word_t               modulus_q;
	word_t               partial_result_q;
	word_t               running_square_q;
	logic [EXP_BITS-1:0] remaining_exponent_q;
	word_t               power_result_q;
	logic                done_q;
	mm_req_t             mm_req_q;
	mm_rsp_t             mm_rsp;
	logic [EXP_BITS-1:0] exp_shifted;

	assign exp_shifted = remaining_exponent_q >> 1;

	mexp_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mm_req_q),
		.modulus (modulus_q),
		.rsp     (mm_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q              <= ST_IDLE;
			modulus_q            <= MODULUS_RESET;
			done_q               <= 1'b0;
			mm_req_q.start       <= 1'b0;
			mm_req_q.a           <= '0;
			mm_req_q.b           <= '0;
			partial_result_q     <= '0;
			running_square_q     <= '0;
			remaining_exponent_q <= '0;
			power_result_q       <= '0;
		end else begin
			done_q         <= 1'b0;
			mm_req_q.start <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				modulus_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						remaining_exponent_q <= exponent[EXP_BITS-1:0];
						if (modulus_q < WORD_TWO) begin
							power_result_q <= '0;
							done_q         <= 1'b1;
						end else begin
							// reduce the base: 1 * base mod m
							mm_req_q.a     <= WORD_ONE;
							mm_req_q.b     <= base;
							mm_req_q.start <= 1'b1;
							state_q        <= ST_REDUCE;
						end
					end
				end
				ST_REDUCE: begin
					if (mm_rsp.done) begin
						running_square_q <= mm_rsp.res;
						partial_result_q <= WORD_ONE;
						state_q          <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (remaining_exponent_q == '0) begin
						power_result_q <= partial_result_q;
						done_q         <= 1'b1;
						state_q        <= ST_IDLE;
					end else if (remaining_exponent_q[0]) begin
						mm_req_q.a     <= partial_result_q;
						mm_req_q.b     <= running_square_q;
						mm_req_q.start <= 1'b1;
						state_q        <= ST_MUL;
					end else begin
						remaining_exponent_q <= exp_shifted;
						mm_req_q.a           <= running_square_q;
						mm_req_q.b           <= running_square_q;
						mm_req_q.start       <= 1'b1;
						state_q              <= ST_SQR;
					end
				end
				ST_MUL: begin
					if (mm_rsp.done) begin
						partial_result_q     <= mm_rsp.res;
						remaining_exponent_q <= exp_shifted;
						// drop the final squaring once no exponent bits remain
						if (exp_shifted == '0) begin
							state_q <= ST_STEP;
						end else begin
							mm_req_q.a     <= running_square_q;
							mm_req_q.b     <= running_square_q;
							mm_req_q.start <= 1'b1;
							state_q        <= ST_SQR;
						end
					end
				end
				ST_SQR: begin
					if (mm_rsp.done) begin
						running_square_q <= mm_rsp.res;
						state_q          <= ST_STEP;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign power_result = power_result_q;
	assign cfg_ready    = (state_q == ST_IDLE) && !start;

	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		done && (modulus_q >= WORD_TWO) |-> (power_result < modulus_q))
		else $error("result not reduced by modulus");

	a_small_modulus: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (modulus_q < WORD_TWO) |=> done && (power_result == '0))
		else $error("modulus below two did not give zero");

	a_mul_owned: assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.done |-> (state_q == ST_REDUCE || state_q == ST_MUL || state_q == ST_SQR))
		else $error("multiplier finished with no product outstanding");

	a_no_start_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mm_req_q.start |=> busy && !done)
		else $error("product launched while sequencer idle");

endmodule

// ===== design/mexp_mulmod.sv =====
// Bit-serial modular multiplier: (a * b) mod m, one multiplier bit per cycle.
// Depends on mexp_pkg.
module mexp_mulmod (
	input  logic              clk,
	input  logic              arst_n,
	input  mexp_pkg::mm_req_t req,
	input  mexp_pkg::word_t   modulus,
	output mexp_pkg::mm_rsp_t rsp
);
	import mexp_pkg::*;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	word_t             acc_q;
	word_t             a_q;
	word_t             b_q;
	logic              done_q;

	logic [DATA_W+1:0] sum;
	logic [DATA_W+1:0] m1;
	logic [DATA_W+1:0] m2;
	logic [DATA_W+1:0] red;
	word_t             acc_next;

	// acc stays below m, so 2*acc + a stays below 3m: at most 2m to take off
	always_comb begin
		m1  = {2'b00, modulus};
		m2  = {1'b0, modulus, 1'b0};
		sum = {1'b0, acc_q, 1'b0} + (b_q[DATA_W-1] ? {2'b00, a_q} : '0);
		if (sum >= m2) begin
			red = sum - m2;
		end else if (sum >= m1) begin
			red = sum - m1;
		end else begin
			red = sum;
		end
		acc_next = red[DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
			acc_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				acc_q  <= '0;
				a_q    <= req.a;
				b_q    <= req.b;
			end else if (busy_q) begin
				acc_q <= acc_next;
				b_q   <= {b_q[DATA_W-2:0], 1'b0};
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = acc_q;

endmodule

// ===== sim/mexp_monitor.sv =====
// Result monitor for mod_exp: follows the start, result and modulus channels,
// predicts each power and compares it with the block's output.
// Depends on mexp_pkg only.
module mexp_monitor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  mexp_pkg::word_t            base,
	input  logic [mexp_pkg::EXP_W-1:0] exponent,
	input  logic                       done,
	input  mexp_pkg::word_t            power_result,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  mexp_pkg::word_t            cfg_data,
	output int                         fail_count,
	output int                         pending
);
	import mexp_pkg::*;

	word_t            modulus_q;
	word_t            acc;
	word_t            sq;
	logic [EXP_W-1:0] rem_exp;
	word_t            expected_powers[$];

	function automatic word_t mulmod(word_t a, word_t b, word_t m);
		bit [63:0] prod;
		prod = {33'b0, a} * {33'b0, b};
		return word_t'(prod % {33'b0, m});
	endfunction

	// Right-to-left square-and-multiply over the held state copy
	function automatic word_t predict_power(word_t b, logic [EXP_W-1:0] e);
		if (modulus_q < WORD_TWO) begin
			acc     = '0;
			sq      = '0;
			rem_exp = '0;
			return '0;
		end
		acc     = WORD_ONE;
		sq      = mulmod(b, WORD_ONE, modulus_q);
		rem_exp = e;
		while (rem_exp != '0) begin
			if (rem_exp[0])
				acc = mulmod(acc, sq, modulus_q);
			rem_exp = rem_exp >> 1;
			sq      = mulmod(sq, sq, modulus_q);
		end
		return acc;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		word_t want;
		if (!arst_n) begin
			modulus_q  = MODULUS_RESET;
			acc        = '0;
			sq         = '0;
			rem_exp    = '0;
			expected_powers.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			// retire the finished result before queueing a newly accepted item
			if (done) begin
				if (expected_powers.size() == 0) begin
					$error("power_result: unexpected result %0d, nothing pending",
						power_result);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_powers.pop_front();
					if (power_result !== want) begin
						$error("power_result: expected %0d, actual %0d", want,
							power_result);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				modulus_q = cfg_data;
			if (start && !busy)
				expected_powers.push_back(predict_power(base, exponent));
			pending <= expected_powers.size();
		end
	end

endmodule

// ===== sim/tb_mod_exp.sv =====
// Stimulus top for mod_exp: directed corner items, then phases of random items
// under several modulus settings and sender idling rates.
// Depends on mexp_pkg, mod_exp and mexp_monitor.
module tb_mod_exp;
	import mexp_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	word_t            base;
	logic [EXP_W-1:0] exponent;
	logic             done;
	word_t            power_result;
	logic             cfg_valid;
	logic             cfg_ready;
	word_t            cfg_data;
	int               fail_count;
	int               pending;

	int               idle_pct;
	int               n_items;
	int               n_cfg;

	localparam logic [EXP_W-1:0] EXP_MAX = '1;
	localparam word_t            BASE_MAX = '1;

	mod_exp dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.base         (base),
		.exponent     (exponent),
		.done         (done),
		.power_result (power_result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	mexp_monitor u_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.base         (base),
		.exponent     (exponent),
		.done         (done),
		.power_result (power_result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always #5 clk = ~clk;

	// Called at a falling edge; returns at the falling edge after the transfer,
	// leaving start high so that a following item can go out back to back.
	task automatic send_item(word_t b, logic [EXP_W-1:0] e);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start    <= 1'b1;
		base     <= b;
		exponent <= e;
		do @(posedge clk); while (busy);
		@(negedge clk);
		n_items++;
	endtask

	task automatic write_modulus(word_t m);
		start <= 1'b0;
		while (pending != 0 || busy)
			@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_cfg++;
	endtask

	// Bias towards values around the modulus and the field extremes
	function automatic word_t rand_base(word_t m);
		unique case ($urandom_range(9))
			0: return '0;
			1: return m - WORD_ONE;
			2: return m;
			3: return m + WORD_ONE;
			4: return BASE_MAX;
			5: return WORD_ONE;
			default: return word_t'($urandom);
		endcase
	endfunction

	// Mostly short exponents to keep items quick; a few use the full width
	function automatic logic [EXP_W-1:0] rand_exponent();
		logic [63:0] raw;
		int          width;
		int          r;
		raw = {$urandom, $urandom};
		r   = $urandom_range(99);
		if (r < 5)
			return '0;
		else if (r < 82)
			width = $urandom_range(8, 1);
		else if (r < 95)
			width = $urandom_range(32, 9);
		else
			width = EXP_W;
		return EXP_W'(raw & ((64'd1 << width) - 64'd1));
	endfunction

	initial begin
		word_t m;
		int    len;
		clk       = 1'b0;
		arst_n    = 1'b0;
		start     = 1'b0;
		base      = '0;
		exponent  = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		idle_pct  = 0;
		n_items   = 0;
		n_cfg     = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corner items under the reset modulus
		send_item('0, '0);
		send_item('0, EXP_W'(5));
		send_item(BASE_MAX, '0);
		send_item(BASE_MAX, EXP_MAX);
		send_item(BASE_MAX, EXP_W'(1));
		send_item(WORD_ONE, EXP_MAX);
		send_item(WORD_TWO, EXP_W'(1));
		send_item(WORD_TWO, EXP_W'(62));
		send_item(WORD_TWO, EXP_MAX >> 1);
		send_item(MODULUS_RESET, EXP_W'(3));
		send_item(MODULUS_RESET + WORD_ONE, EXP_W'(12345));
		send_item(MODULUS_RESET - WORD_ONE, EXP_W'(2));
		send_item(word_t'(3), EXP_W'(1) << (EXP_W - 1));
		send_item(word_t'(7), EXP_W'({(EXP_W + 1) / 2{2'b01}}));
		send_item(word_t'(7), EXP_W'({(EXP_W + 1) / 2{2'b10}}));
		send_item(word_t'(123456789), EXP_W'(1000000006));
		send_item(word_t'($urandom), EXP_MAX);
		send_item(word_t'($urandom), EXP_MAX);

		for (int p = 0; p < 10; p++) begin
			len = 170;
			unique case (p)
				0: m = WORD_TWO;
				1: m = BASE_MAX;
				2: m = word_t'($urandom_range(32'h7FFF_FFFF, 2));
				3: m = word_t'(3);
				4: begin
					m   = WORD_ONE;
					len = 60;
				end
				5: m = MODULUS_RESET;
				6: begin
					m   = '0;
					len = 60;
				end
				7: m = word_t'($urandom_range(1000, 2));
				8: m = word_t'($urandom) | word_t'(32'h4000_0000);
				default: m = word_t'(65521);
			endcase
			write_modulus(m);
			unique case (p % 3)
				0: idle_pct = 0;
				1: idle_pct = 74;
				default: idle_pct = 32;
			endcase
			repeat (len)
				send_item(rand_base(m), rand_exponent());
		end

		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		// allow for a stray result past the last expected one
		repeat (200) @(negedge clk);

		$display("Ran %0d items across %0d modulus writes (0, 1, 2, 3, 2^31-1, random),",
			n_items, n_cfg);
		$display("with sender idling at 0, 32 and 74 percent.");
		if (fail_count == 0 && pending == 0)
			$display("mod_exp: match");
		else
			$display("mod_exp: mismatch");
		$finish;
	end

	initial begin
		#300000000;
		$display("mod_exp: mismatch");
		$finish;
	end

endmodule
